// File: rtl/core/fhr_pkg.sv
// fhr_pkg: shared types and constants for the frame header receiver
// used by fhr_parser, fhr_out_reg and frame_header_receiver; no dependencies
`timescale 1ns / 1ps

package fhr_pkg;

   // configuration register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND = 1'b1;

   // reset values of the magic bytes, ASCII F and R
   localparam logic [CSR_DATA_W-1:0] MAGIC_FIRST_RST  = 8'd70;
   localparam logic [CSR_DATA_W-1:0] MAGIC_SECOND_RST = 8'd82;

   // header byte positions
   localparam logic [2:0] HDR_MAGIC2 = 3'd1;
   localparam logic [2:0] HDR_W_LO   = 3'd2;
   localparam logic [2:0] HDR_W_HI   = 3'd3;
   localparam logic [2:0] HDR_H_LO   = 3'd4;
   localparam logic [2:0] HDR_H_HI   = 3'd5;
   localparam logic [2:0] HDR_LAST   = 3'd7;
   localparam logic [2:0] HDR_START  = 3'd1;

   localparam int BYTES_PER_PIXEL = 3;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_PIXELS = 2'd2
   } phase_type;

   // one result beat
   typedef struct packed {
      logic        pixel_write;
      logic [15:0] pixel_index;
      logic [7:0]  pixel_data;
      logic        frame_done;
      logic [7:0]  frame_width;
      logic [7:0]  frame_height;
      logic        header_rejected;
   } rsp_type;

endpackage

// File: rtl/core/fhr_in_reg.sv
// fhr_in_reg: input register for one byte beat
// depends on nothing; stall comes from the downstream advance signal
`timescale 1ns / 1ps

module fhr_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       advance,
   output logic       fire,
   output logic [7:0] data_byte
);

   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;
   logic       accept;

   // hold the beat until the parser takes it
   assign req_stall = vld_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign vld_in    = accept | (vld_ff & ~advance);
   assign fire      = vld_ff & advance;
   assign data_byte = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
      end
   end

endmodule

// File: rtl/core/fhr_parser.sv
// fhr_parser: header collection, size check and pixel counting
// depends on fhr_pkg; one byte is processed per fire
`timescale 1ns / 1ps

module fhr_parser import fhr_pkg::*; #(
   parameter int MAX_SIDE = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            data_byte,
   input  logic [CSR_DATA_W-1:0] magic_first,
   input  logic [CSR_DATA_W-1:0] magic_second,
   output rsp_type               rsp
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CNT_N  = $clog2(BYTES_PER_PIXEL * MAX_SIDE * MAX_SIDE + 1);
   localparam int CW     = (CNT_N > 16) ? CNT_N : 16;

   phase_type     phase_ff, phase_in;
   logic [2:0]    hcnt_ff, hcnt_in;
   logic [7:0]    mag2_ff, mag2_in;
   logic [7:0]    w_lo_ff, w_lo_in, w_hi_ff, w_hi_in;
   logic [7:0]    h_lo_ff, h_lo_in, h_hi_ff, h_hi_in;
   logic [CW-1:0] expected_ff, expected_in;
   logic [CW-1:0] received_ff, received_in;

   logic [15:0]         width_w, height_w;
   logic                header_ok;
   logic [2*SIDE_W-1:0] area;
   logic [CW-1:0]       received_inc;

   // header checks on the stored bytes
   assign width_w   = {w_hi_ff, w_lo_ff};
   assign height_w  = {h_hi_ff, h_lo_ff};
   assign header_ok = (mag2_ff == magic_second)
                   && (width_w != 16'd0) && (width_w <= 16'(MAX_SIDE))
                   && (height_w != 16'd0) && (height_w <= 16'(MAX_SIDE));
   assign area         = width_w[SIDE_W-1:0] * height_w[SIDE_W-1:0];
   assign received_inc = received_ff + CW'(1);

   // next state and result
   always_comb begin
      phase_in    = phase_ff;
      hcnt_in     = hcnt_ff;
      mag2_in     = mag2_ff;
      w_lo_in     = w_lo_ff;
      w_hi_in     = w_hi_ff;
      h_lo_in     = h_lo_ff;
      h_hi_in     = h_hi_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      rsp         = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            unique case (hcnt_ff)
               HDR_MAGIC2: mag2_in = data_byte;
               HDR_W_LO:   w_lo_in = data_byte;
               HDR_W_HI:   w_hi_in = data_byte;
               HDR_H_LO:   h_lo_in = data_byte;
               HDR_H_HI:   h_hi_in = data_byte;
               default:    ;
            endcase
            hcnt_in = hcnt_ff + 3'd1;
            if (hcnt_ff == HDR_LAST) begin
               hcnt_in = '0;
               if (header_ok) begin
                  expected_in = CW'(area) * CW'(BYTES_PER_PIXEL);
                  received_in = '0;
                  phase_in    = PH_PIXELS;
               end else begin
                  rsp.header_rejected = 1'b1;
                  phase_in            = PH_IDLE;
               end
            end
         end
         PH_PIXELS: begin
            rsp.pixel_write = 1'b1;
            rsp.pixel_index = received_ff[15:0];
            rsp.pixel_data  = data_byte;
            received_in     = received_inc;
            if (received_inc >= expected_ff) begin
               rsp.frame_done   = 1'b1;
               rsp.frame_width  = w_lo_ff;
               rsp.frame_height = h_lo_ff;
               phase_in         = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (data_byte == magic_first) begin
               hcnt_in  = HDR_START;
               phase_in = PH_HEADER;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hcnt_ff     <= '0;
         expected_ff <= '0;
         received_ff <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         hcnt_ff     <= hcnt_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
      end
   end

   // header bytes
   always_ff @(posedge clock) begin
      if (fire) begin
         mag2_ff <= mag2_in;
         w_lo_ff <= w_lo_in;
         w_hi_ff <= w_hi_in;
         h_lo_ff <= h_lo_in;
         h_hi_ff <= h_hi_in;
      end
   end

endmodule

// File: rtl/core/fhr_out_reg.sv
// fhr_out_reg: result register between the parser and the rsp channel
// depends on fhr_pkg for the result type
`timescale 1ns / 1ps

module fhr_out_reg import fhr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  rsp_type rsp_next,
   output logic    advance,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic    vld_ff, vld_in;
   rsp_type rsp_ff;

   // room for a new beat when empty or the held one leaves
   assign advance   = ~vld_ff | ~rsp_stall;
   assign vld_in    = fire | (vld_ff & rsp_stall);
   assign rsp_valid = vld_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

// File: rtl/core/frame_header_receiver.sv
// frame_header_receiver: byte-serial frame header parser and pixel indexer
// path: a req beat passes the input register, then the result register, on its way to the rsp beat
// throughput: one byte per cycle, one rsp beat per req beat; limited only by rsp_stall
// reset: synchronous, clears phase and counters, magic bytes return to 'F' and 'R'
// depends on fhr_pkg, fhr_in_reg, fhr_parser, fhr_out_reg
`timescale 1ns / 1ps

module frame_header_receiver import fhr_pkg::*; #(
   parameter int MAX_SIDE = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pixel_write,
   output logic [15:0]           rsp_pixel_index,
   output logic [7:0]            rsp_pixel_data,
   output logic                  rsp_frame_done,
   output logic [7:0]            rsp_frame_width,
   output logic [7:0]            rsp_frame_height,
   output logic                  rsp_header_rejected,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                  advance, fire;
   logic [7:0]            data_byte;
   rsp_type               rsp_next, rsp;
   logic [CSR_DATA_W-1:0] magic_first_ff, magic_second_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= MAGIC_FIRST_RST;
         magic_second_ff <= MAGIC_SECOND_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAGIC_FIRST:  magic_first_ff  <= csr_wdata;
            CSR_MAGIC_SECOND: magic_second_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   fhr_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .fire          (fire),
      .data_byte     (data_byte)
   );

   fhr_parser #(
      .MAX_SIDE (MAX_SIDE)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .data_byte    (data_byte),
      .magic_first  (magic_first_ff),
      .magic_second (magic_second_ff),
      .rsp          (rsp_next)
   );

   fhr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rsp_next  (rsp_next),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // result fields
   assign rsp_pixel_write     = rsp.pixel_write;
   assign rsp_pixel_index     = rsp.pixel_index;
   assign rsp_pixel_data      = rsp.pixel_data;
   assign rsp_frame_done      = rsp.frame_done;
   assign rsp_frame_width     = rsp.frame_width;
   assign rsp_frame_height    = rsp.frame_height;
   assign rsp_header_rejected = rsp.header_rejected;

endmodule

// File: rtl/core/fhr_checker.sv
// fhr_checker: port-level assertions for frame_header_receiver, bound to the top level
// no package dependencies; watches the handshake and result ports
`timescale 1ns / 1ps

module fhr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_pixel_write,
   input logic [15:0] rsp_pixel_index,
   input logic [7:0]  rsp_pixel_data,
   input logic        rsp_frame_done,
   input logic [7:0]  rsp_frame_width,
   input logic [7:0]  rsp_frame_height,
   input logic        rsp_header_rejected
);

   // no result beat and no input stall right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("rsp_valid or req_stall high right after reset");

   // frame done only on a pixel beat
   a_done_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_pixel_write)
      else $error("frame_done without pixel_write");

   // a rejected header never carries pixel data
   a_reject_not_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_rejected |-> !rsp_pixel_write && rsp_pixel_index == 16'd0
         && rsp_pixel_data == 8'd0)
      else $error("header_rejected together with pixel fields");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_write)
         && $stable(rsp_pixel_index) && $stable(rsp_pixel_data) && $stable(rsp_frame_done)
         && $stable(rsp_frame_width) && $stable(rsp_frame_height)
         && $stable(rsp_header_rejected))
      else $error("stalled rsp beat changed");

endmodule

bind frame_header_receiver fhr_checker u_fhr_checker (.*);
